/* src/vsss_pkg.sv */
// Shared types and constants of the speaker subset selector.
// No dependencies; used by the front end, queue, back end and top level.
`default_nettype none

package vsss_pkg;

    // Operation codes of an input transaction
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Tier codes of a result
    localparam logic [2:0] TIER_FLAT   = 3'd0;
    localparam logic [2:0] TIER_STRICT = 3'd1;
    localparam logic [2:0] TIER_MID    = 3'd2;
    localparam logic [2:0] TIER_LOOSE  = 3'd3;
    localparam logic [2:0] TIER_WIDE   = 3'd4;
    localparam logic [2:0] TIER_GROUP  = 3'd5;
    localparam int         NUM_TIERS   = 6;

    // Configuration register indexes
    localparam logic [2:0] CFG_SPEAKER_COUNT = 3'd0;
    localparam logic [2:0] CFG_COS_STRICT    = 3'd1;
    localparam logic [2:0] CFG_COS_MID       = 3'd2;
    localparam logic [2:0] CFG_COS_LOOSE     = 3'd3;
    localparam logic [2:0] CFG_COS_WIDE      = 3'd4;
    localparam logic [2:0] CFG_STEEP_UZ      = 3'd5;
    localparam logic [2:0] CFG_LAYER_Z       = 3'd6;
    localparam logic [2:0] CFG_Z_EPS         = 3'd7;

    // Cosine below this value disables the cone test
    localparam logic signed [15:0] COS_NO_ANGLE = -16'sd16384;

    typedef struct packed {
        logic [5:0]         speaker_count;
        logic signed [15:0] cos_strict;
        logic signed [15:0] cos_mid;
        logic signed [15:0] cos_loose;
        logic signed [15:0] cos_wide;
        logic [14:0]        steep_source_uz;
        logic signed [15:0] opposite_layer_z;
        logic [14:0]        horizontal_z_eps;
    } cfg_t;

    // Classified transaction handed from front end to back end
    typedef struct packed {
        logic               operation;
        logic [4:0]         speaker_index;
        logic signed [15:0] speaker_x;
        logic signed [15:0] speaker_y;
        logic signed [15:0] speaker_z;
        logic               speaker_in_group;
        logic signed [15:0] object_x;
        logic signed [15:0] object_y;
        logic signed [15:0] object_z;
        logic               object_flat;
        logic               dir_zero;
        logic [61:0]        cone_k0;
        logic [61:0]        cone_k1;
        logic [61:0]        cone_k2;
        logic [61:0]        cone_k3;
        logic               steep_up;
        logic               steep_down;
    } q_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_PICK
    } back_state_t;

endpackage

`default_nettype wire

/* src/vsss_if.sv */
// Valid/ready channel interfaces of the speaker subset selector.
// No dependencies; used by the front end, back end and top level.
`default_nettype none

interface vsss_in_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic [4:0]         speaker_index;
    logic signed [15:0] speaker_x;
    logic signed [15:0] speaker_y;
    logic signed [15:0] speaker_z;
    logic               speaker_in_group;
    logic signed [15:0] object_x;
    logic signed [15:0] object_y;
    logic signed [15:0] object_z;
    logic               object_flat;

    modport source (
        output valid, operation, speaker_index, speaker_x, speaker_y, speaker_z,
               speaker_in_group, object_x, object_y, object_z, object_flat,
        input  ready
    );
    modport sink (
        input  valid, operation, speaker_index, speaker_x, speaker_y, speaker_z,
               speaker_in_group, object_x, object_y, object_z, object_flat,
        output ready
    );
endinterface

interface vsss_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] speaker_mask;
    logic [5:0]  selected_count;
    logic [2:0]  chosen_tier;

    modport source (
        output valid, speaker_mask, selected_count, chosen_tier,
        input  ready
    );
    modport sink (
        input  valid, speaker_mask, selected_count, chosen_tier,
        output ready
    );
endinterface

`default_nettype wire

/* src/vsss_ram.sv */
// Generic one-write, one-read RAM with registered read data.
// No dependencies; holds the speaker position table.
`default_nettype none

module vsss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire  [$clog2(DEPTH)-1:0] waddr,
    input  wire  [WIDTH-1:0]         wdata,
    input  wire  [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* src/vsss_front.sv */
// Front end: accepts transactions, squares the direction and forms the
// per-query cone thresholds and steep flags. Depends on vsss_pkg, vsss_if.
`default_nettype none

module vsss_front (
    input  wire              clk,
    input  wire              rst_n,
    vsss_in_if.sink          in_ch,
    input  vsss_pkg::cfg_t   cfg,
    input  wire              q_full,
    output logic             q_push,
    output vsss_pkg::q_entry_t q_data
);
    import vsss_pkg::*;

    logic               adv;
    logic               v1_reg, v2_reg, v3_reg;
    q_entry_t           e1_reg, e2_reg, e3_reg;
    logic [30:0]        ox2_reg, oy2_reg, oz2_reg;
    logic [30:0]        c2_reg [4];
    logic [29:0]        su2_reg, su2b_reg;
    logic [30:0]        c2b_reg [4];
    logic [31:0]        o2_reg;
    logic [58:0]        lhs_reg, lhs3_reg;
    logic [61:0]        k_reg [4];
    logic [61:0]        rhs_reg;
    logic               dz3_reg;
    logic signed [31:0] sq_ox, sq_oy, sq_oz;
    logic signed [31:0] sq_c [4];
    logic signed [15:0] cos_v [4];
    q_entry_t           in_e;
    logic [62:0]        kp [4];
    logic               steep;

    // Advance the whole pipeline unless the last stage is blocked
    assign adv         = !v3_reg || !q_full;
    assign in_ch.ready = adv;
    assign q_push      = v3_reg && !q_full;

    always_comb
    begin
        cos_v[0] = cfg.cos_strict;
        cos_v[1] = cfg.cos_mid;
        cos_v[2] = cfg.cos_loose;
        cos_v[3] = cfg.cos_wide;
        sq_ox = in_ch.object_x * in_ch.object_x;
        sq_oy = in_ch.object_y * in_ch.object_y;
        sq_oz = in_ch.object_z * in_ch.object_z;
        for (int k = 0; k < 4; k++)
        begin
            sq_c[k] = cos_v[k] * cos_v[k];
            kp[k]   = 63'(c2b_reg[k]) * 63'(o2_reg);
        end
        in_e                  = '0;
        in_e.operation        = in_ch.operation;
        in_e.speaker_index    = in_ch.speaker_index;
        in_e.speaker_x        = in_ch.speaker_x;
        in_e.speaker_y        = in_ch.speaker_y;
        in_e.speaker_z        = in_ch.speaker_z;
        in_e.speaker_in_group = in_ch.speaker_in_group;
        in_e.object_x         = in_ch.object_x;
        in_e.object_y         = in_ch.object_y;
        in_e.object_z         = in_ch.object_z;
        in_e.object_flat      = in_ch.object_flat;
    end

    // Valid bits of the three stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_ch.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Stage 1: squares; stage 2: |o|^2; stage 3: thresholds times |o|^2
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e1_reg  <= in_e;
            ox2_reg <= sq_ox[30:0];
            oy2_reg <= sq_oy[30:0];
            oz2_reg <= sq_oz[30:0];
            su2_reg <= 30'(cfg.steep_source_uz) * 30'(cfg.steep_source_uz);
            for (int k = 0; k < 4; k++)
            begin
                c2_reg[k]  <= sq_c[k][30:0];
                c2b_reg[k] <= c2_reg[k];
                k_reg[k]   <= kp[k][61:0];
            end

            e2_reg   <= e1_reg;
            o2_reg   <= 32'(ox2_reg) + 32'(oy2_reg) + 32'(oz2_reg);
            lhs_reg  <= {oz2_reg[30:0], 28'b0};
            su2b_reg <= su2_reg;

            e3_reg   <= e2_reg;
            lhs3_reg <= lhs_reg;
            rhs_reg  <= 62'(su2b_reg) * 62'(o2_reg);
            dz3_reg  <= (o2_reg == 32'd0);
        end
    end

    // Classify steepness and hand the transaction over
    always_comb
    begin
        steep  = (e3_reg.object_z != 16'sd0) && (62'(lhs3_reg) > rhs_reg);
        q_data = e3_reg;
        q_data.dir_zero   = dz3_reg;
        q_data.cone_k0    = k_reg[0];
        q_data.cone_k1    = k_reg[1];
        q_data.cone_k2    = k_reg[2];
        q_data.cone_k3    = k_reg[3];
        q_data.steep_up   = steep && !e3_reg.object_z[15];
        q_data.steep_down = steep && e3_reg.object_z[15];
    end

endmodule

`default_nettype wire

/* src/vsss_fifo.sv */
// Two-entry queue between front end and back end.
// Depends on vsss_pkg for the entry type.
`default_nettype none

module vsss_fifo (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                push,
    input  vsss_pkg::q_entry_t push_data,
    output logic               full,
    input  wire                pop,
    output vsss_pkg::q_entry_t pop_data,
    output logic               empty
);
    import vsss_pkg::*;

    q_entry_t   mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

`default_nettype wire

/* src/vsss_back.sv */
// Back end: writes speaker entries, walks the table one speaker per cycle
// testing all tiers at once, then picks a tier. Depends on vsss_pkg, vsss_if, vsss_ram.
`default_nettype none

module vsss_back #(
    parameter int DEPTH        = 32,
    parameter int MIN_SELECTED = 3
) (
    input  wire                clk,
    input  wire                rst_n,
    input  vsss_pkg::cfg_t     cfg,
    input  wire                q_empty,
    input  vsss_pkg::q_entry_t q_data,
    output logic               q_pop,
    vsss_out_if.source         out_ch
);
    import vsss_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    back_state_t        state_reg, state_next;
    logic [CW-1:0]      walk_reg, walk_next;
    logic [CW-1:0]      n_spk;
    logic [5:0]         n_full;
    q_entry_t           qry_reg;
    logic               issue, start_query, ram_we, pick_fire;

    // Walk pipeline
    logic               v0_reg, v1_reg, v2_reg, v3_reg;
    logic [AW-1:0]      i0_reg, i1_reg, i2_reg, i3_reg;
    logic [48:0]        rdata;
    logic signed [15:0] rd_x, rd_y, rd_z;
    logic signed [31:0] px_reg, py_reg, pz_reg, qx_reg, qy_reg, qz_reg;
    logic signed [15:0] z1_reg, z2_reg, z3_reg;
    logic               g1_reg, g2_reg, g3_reg;
    logic signed [33:0] dsum;
    logic [31:0]        ad_reg, s2_reg;
    logic               dneg_reg, dneg3_reg, s2nz_reg;
    logic [63:0]        d2_reg;
    logic [63:0]        lo_reg [4];
    logic [61:0]        hi_reg [4];
    logic [61:0]        kv [4];

    // Tier results
    logic [31:0]        mask_reg [NUM_TIERS];
    logic [5:0]         cnt_reg  [NUM_TIERS];
    logic [NUM_TIERS-1:0] hit;
    logic signed [15:0] cos_v [4];
    logic [3:0]         noang;
    logic [16:0]        zabs;
    logic [93:0]        lhs, rhs;
    logic               cone;
    logic [2:0]         tier;

    // Output register
    logic               ov_reg;
    logic [31:0]        omask_reg;
    logic [5:0]         ocnt_reg;
    logic [2:0]         otier_reg;

    assign out_ch.valid          = ov_reg;
    assign out_ch.speaker_mask   = omask_reg;
    assign out_ch.selected_count = ocnt_reg;
    assign out_ch.chosen_tier    = otier_reg;

    assign n_full = (cfg.speaker_count > 6'(DEPTH)) ? 6'(DEPTH) : cfg.speaker_count;
    assign n_spk  = n_full[CW-1:0];

    vsss_ram #(
        .WIDTH (49),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (q_data.speaker_index[AW-1:0]),
        .wdata ({q_data.speaker_in_group, q_data.speaker_z,
                 q_data.speaker_y, q_data.speaker_x}),
        .raddr (walk_reg[AW-1:0]),
        .rdata (rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty && q_data.operation == OP_QUERY)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (walk_reg == n_spk)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!v0_reg && !v1_reg && !v2_reg && !v3_reg)
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                if (!ov_reg || out_ch.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        q_pop       = 1'b0;
        ram_we      = 1'b0;
        start_query = 1'b0;
        issue       = 1'b0;
        pick_fire   = 1'b0;
        walk_next   = walk_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                q_pop       = !q_empty;
                ram_we      = !q_empty && q_data.operation == OP_LOAD
                              && int'(q_data.speaker_index) < DEPTH;
                start_query = !q_empty && q_data.operation == OP_QUERY;
                walk_next   = '0;
            end
            ST_WALK:
            begin
                issue = (walk_reg != n_spk);
                if (issue)
                begin
                    walk_next = walk_reg + CW'(1);
                end
            end
            ST_DRAIN: ;
            ST_PICK:
            begin
                pick_fire = !ov_reg || out_ch.ready;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            walk_reg  <= '0;
            v0_reg    <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            walk_reg  <= walk_next;
            v0_reg    <= issue;
            v1_reg    <= v0_reg;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
        end
    end

    // Latch the query
    always_ff @(posedge clk)
    begin
        if (start_query)
        begin
            qry_reg <= q_data;
        end
    end

    // Walk datapath: products, sums, wide products
    assign rd_x = rdata[15:0];
    assign rd_y = rdata[31:16];
    assign rd_z = rdata[47:32];

    always_comb
    begin
        dsum  = 34'(px_reg) + 34'(py_reg) + 34'(pz_reg);
        kv[0] = qry_reg.cone_k0;
        kv[1] = qry_reg.cone_k1;
        kv[2] = qry_reg.cone_k2;
        kv[3] = qry_reg.cone_k3;
    end

    always_ff @(posedge clk)
    begin
        i0_reg <= walk_reg[AW-1:0];

        i1_reg <= i0_reg;
        px_reg <= rd_x * qry_reg.object_x;
        py_reg <= rd_y * qry_reg.object_y;
        pz_reg <= rd_z * qry_reg.object_z;
        qx_reg <= rd_x * rd_x;
        qy_reg <= rd_y * rd_y;
        qz_reg <= rd_z * rd_z;
        z1_reg <= rd_z;
        g1_reg <= rdata[48];

        i2_reg   <= i1_reg;
        dneg_reg <= dsum[33];
        ad_reg   <= dsum[33] ? 32'(-dsum) : dsum[31:0];
        s2_reg   <= 32'(qx_reg[30:0]) + 32'(qy_reg[30:0]) + 32'(qz_reg[30:0]);
        z2_reg   <= z1_reg;
        g2_reg   <= g1_reg;

        i3_reg    <= i2_reg;
        d2_reg    <= ad_reg * ad_reg;
        dneg3_reg <= dneg_reg;
        s2nz_reg  <= (s2_reg != 32'd0);
        z3_reg    <= z2_reg;
        g3_reg    <= g2_reg;
        for (int k = 0; k < 4; k++)
        begin
            lo_reg[k] <= kv[k][31:0] * s2_reg;
            hi_reg[k] <= kv[k][61:32] * s2_reg;
        end
    end

    // Tier tests of one speaker
    always_comb
    begin
        cos_v[0] = cfg.cos_strict;
        cos_v[1] = cfg.cos_mid;
        cos_v[2] = cfg.cos_loose;
        cos_v[3] = cfg.cos_wide;
        zabs = z3_reg[15] ? 17'(-(17'(z3_reg))) : 17'(z3_reg);
        lhs  = {2'b00, d2_reg, 28'b0};
        hit  = '0;
        hit[TIER_FLAT]  = g3_reg && (zabs <= 17'(cfg.horizontal_z_eps));
        hit[TIER_GROUP] = g3_reg && s2nz_reg;
        for (int k = 0; k < 4; k++)
        begin
            noang[k] = cos_v[k] < COS_NO_ANGLE;
            rhs      = {hi_reg[k], 32'b0} + 94'(lo_reg[k]);
            if (qry_reg.dir_zero)
            begin
                cone = (cos_v[k] <= 16'sd0);
            end
            else if (!cos_v[k][15])
            begin
                cone = !dneg3_reg && (lhs >= rhs);
            end
            else
            begin
                cone = !dneg3_reg || (lhs <= rhs);
            end
            hit[k+1] = g3_reg && s2nz_reg && (noang[k] || cone);
            if (k < 2)
            begin
                if (qry_reg.steep_up && z3_reg <= cfg.opposite_layer_z)
                begin
                    hit[k+1] = 1'b0;
                end
                if (qry_reg.steep_down && z3_reg >= cfg.opposite_layer_z)
                begin
                    hit[k+1] = 1'b0;
                end
            end
        end
    end

    // Accumulate masks and counts
    always_ff @(posedge clk)
    begin
        for (int t = 0; t < NUM_TIERS; t++)
        begin
            if (start_query)
            begin
                mask_reg[t] <= '0;
                cnt_reg[t]  <= '0;
            end
            else if (v3_reg && hit[t])
            begin
                mask_reg[t][i3_reg] <= 1'b1;
                cnt_reg[t]          <= cnt_reg[t] + 6'd1;
            end
        end
    end

    // Flat for a flat object, else first tier with enough speakers or no angle test, else group
    always_comb
    begin
        priority if (qry_reg.object_flat)
            tier = TIER_FLAT;
        else if (cnt_reg[TIER_STRICT] >= 6'(MIN_SELECTED) || noang[0])
            tier = TIER_STRICT;
        else if (cnt_reg[TIER_MID] >= 6'(MIN_SELECTED) || noang[1])
            tier = TIER_MID;
        else if (cnt_reg[TIER_LOOSE] >= 6'(MIN_SELECTED) || noang[2])
            tier = TIER_LOOSE;
        else if (cnt_reg[TIER_WIDE] >= 6'(MIN_SELECTED) || noang[3])
            tier = TIER_WIDE;
        else
            tier = TIER_GROUP;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (pick_fire)
        begin
            ov_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pick_fire)
        begin
            omask_reg <= mask_reg[tier];
            ocnt_reg  <= cnt_reg[tier];
            otier_reg <= tier;
        end
    end

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> walk_reg <= n_spk)
        else $error("walk index ran past speaker count");

    a_pick_drained: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PICK |-> !v0_reg && !v1_reg && !v2_reg && !v3_reg)
        else $error("tier picked with speakers still in flight");

    a_no_issue_idle: assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> state_reg == ST_WALK)
        else $error("table read issued outside a walk");

    a_result_from_pick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ov_reg) |-> $past(state_reg) == ST_PICK)
        else $error("result raised without a pick");

endmodule

`default_nettype wire

/* src/vbap_speaker_subset_select_top.sv */
// Top level of the speaker subset selector: APB register file, front end,
// queue and back end. Depends on vsss_pkg, vsss_if, vsss_front, vsss_fifo, vsss_back.
`default_nettype none

// A load transaction writes one speaker entry and returns nothing; a query
// returns one mask with its count and tier. The front end takes a
// transaction every cycle while its three-stage pipeline and the two-entry
// queue have room. The back end writes a load into the table as it pops
// it. For a query it reads the clamped speaker count of entries, one
// speaker per cycle through a single RAM read port and a four-stage test
// pipeline, then drains and resolves them, and takes nothing new until
// the result is registered. Registers sit at byte address 4*index.
module vbap_speaker_subset_select_top #(
    parameter int MAX_SPEAKERS = 32,
    parameter int MIN_SELECTED = 3
) (
    input  wire         clk,
    input  wire         rst_n,
    vsss_in_if.sink     in_ch,
    vsss_out_if.source  out_ch,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [4:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import vsss_pkg::*;

    localparam int DEPTH = (MAX_SPEAKERS < 32) ? MAX_SPEAKERS : 32;

    cfg_t     cfg_reg;
    logic     cfg_we;
    logic     q_push, q_pop, q_full, q_empty;
    q_entry_t q_in, q_out;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    // Configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.speaker_count    <= 6'd0;
            cfg_reg.cos_strict       <= 16'sd13377;
            cfg_reg.cos_mid          <= 16'sd11585;
            cfg_reg.cos_loose        <= 16'sd8192;
            cfg_reg.cos_wide         <= 16'sd0;
            cfg_reg.steep_source_uz  <= 15'd11585;
            cfg_reg.opposite_layer_z <= 16'sd0;
            cfg_reg.horizontal_z_eps <= 15'd102;
        end
        else if (cfg_we)
        begin
            unique case (paddr[4:2])
                CFG_SPEAKER_COUNT: cfg_reg.speaker_count    <= pwdata[5:0];
                CFG_COS_STRICT:    cfg_reg.cos_strict       <= pwdata[15:0];
                CFG_COS_MID:       cfg_reg.cos_mid          <= pwdata[15:0];
                CFG_COS_LOOSE:     cfg_reg.cos_loose        <= pwdata[15:0];
                CFG_COS_WIDE:      cfg_reg.cos_wide         <= pwdata[15:0];
                CFG_STEEP_UZ:      cfg_reg.steep_source_uz  <= pwdata[14:0];
                CFG_LAYER_Z:       cfg_reg.opposite_layer_z <= pwdata[15:0];
                CFG_Z_EPS:         cfg_reg.horizontal_z_eps <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    // Register read back
    always_comb
    begin
        unique case (paddr[4:2])
            CFG_SPEAKER_COUNT: prdata = 32'(cfg_reg.speaker_count);
            CFG_COS_STRICT:    prdata = 32'(unsigned'(cfg_reg.cos_strict));
            CFG_COS_MID:       prdata = 32'(unsigned'(cfg_reg.cos_mid));
            CFG_COS_LOOSE:     prdata = 32'(unsigned'(cfg_reg.cos_loose));
            CFG_COS_WIDE:      prdata = 32'(unsigned'(cfg_reg.cos_wide));
            CFG_STEEP_UZ:      prdata = 32'(cfg_reg.steep_source_uz);
            CFG_LAYER_Z:       prdata = 32'(unsigned'(cfg_reg.opposite_layer_z));
            CFG_Z_EPS:         prdata = 32'(cfg_reg.horizontal_z_eps);
            default:           prdata = '0;
        endcase
    end

    vsss_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .cfg    (cfg_reg),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_in)
    );

    vsss_fifo u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    vsss_back #(
        .DEPTH        (DEPTH),
        .MIN_SELECTED (MIN_SELECTED)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_data  (q_out),
        .q_pop   (q_pop),
        .out_ch  (out_ch)
    );

endmodule

`default_nettype wire

/* tb/vbap_speaker_subset_select_top_test.sv */
// Testbench of the speaker subset selector: drives loads and queries with random
// idling, predicts each mask, count and tier or takes it from a directed row, and checks results in order.
// Depends on vsss_pkg, vsss_if and vbap_speaker_subset_select_top.
`default_nettype none

module vbap_speaker_subset_select_top_test;
    import vsss_pkg::*;

    localparam int NUM_SPK      = 32;
    localparam int MIN_SEL      = 3;
    localparam int NUM_PHASES   = 10;
    localparam int PHASE_ITEMS  = 185;
    localparam int SETTLE       = 150;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef struct packed {
        logic               op;
        logic [4:0]         idx;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] sz;
        logic               grp;
        logic signed [15:0] ox;
        logic signed [15:0] oy;
        logic signed [15:0] oz;
        logic               flat;
    } sel_item_t;

    typedef struct packed {
        logic [31:0] mask;
        logic [5:0]  cnt;
        logic [2:0]  tier;
    } sel_result_t;

    typedef struct {
        sel_item_t   item;
        bit          typed;
        sel_result_t res;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    vsss_in_if  in_ch();
    vsss_out_if out_ch();

    vbap_speaker_subset_select_top i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state: speaker table and register copy
    logic signed [15:0] tab_x [NUM_SPK];
    logic signed [15:0] tab_y [NUM_SPK];
    logic signed [15:0] tab_z [NUM_SPK];
    logic               tab_grp [NUM_SPK];
    cfg_t               cfg;

    sel_result_t expected_selections[$];
    int          errors = 0;
    int          cycles = 0;
    bit          idle_on = 1'b1;
    int          stall_left = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // Cone test by sign and squares: 16384*(s.o) >= c*|s|*|o|
    function automatic bit cone_pass(input longint d, input logic [127:0] s2,
                                     input logic [127:0] o2, input longint c);
        logic [127:0] ad, cm, lhs, rhs;
        if (o2 == 0)
            return c <= 0;
        ad  = (d < 0) ? 128'(-d) : 128'(d);
        cm  = (c < 0) ? 128'(-c) : 128'(c);
        lhs = (ad * ad) << 28;
        rhs = cm * cm * s2 * o2;
        if (c >= 0)
            return d >= 0 && lhs >= rhs;
        return d >= 0 || lhs <= rhs;
    endfunction

    // Update the table for a load; compute the selection for a query
    task automatic predict_selection(input sel_item_t it, output bit has,
                                     output sel_result_t r);
        int           n, t;
        longint       ox, oy, oz, sx, sy, sz, c, zabs;
        logic [127:0] o2, s2, su2, steep_lhs;
        logic [31:0]  mask;
        bit           up, down, noang;
        int           cnt;
        has = 1'b0;
        r = '0;
        if (it.op == OP_LOAD)
        begin
            tab_x[it.idx] = it.sx;
            tab_y[it.idx] = it.sy;
            tab_z[it.idx] = it.sz;
            tab_grp[it.idx] = it.grp;
            return;
        end
        has = 1'b1;
        n = (cfg.speaker_count > NUM_SPK) ? NUM_SPK : int'(cfg.speaker_count);
        mask = '0;
        if (it.flat)
        begin
            for (int i = 0; i < n; i++)
            begin
                zabs = tab_z[i];
                if (zabs < 0)
                    zabs = -zabs;
                if (tab_grp[i] && zabs <= longint'(cfg.horizontal_z_eps))
                    mask[i] = 1'b1;
            end
            r = '{mask, 6'($countones(mask)), TIER_FLAT};
            return;
        end
        ox = it.ox;
        oy = it.oy;
        oz = it.oz;
        o2 = 128'(ox * ox + oy * oy + oz * oz);
        su2 = 128'(longint'(cfg.steep_source_uz) * longint'(cfg.steep_source_uz));
        steep_lhs = 128'(oz * oz) << 28;
        up = 1'b0;
        down = 1'b0;
        if (oz != 0 && steep_lhs > su2 * o2)
        begin
            up = oz > 0;
            down = oz < 0;
        end
        cnt = 0;
        for (t = 1; t <= 5; t++)
        begin
            case (t)
                1: c = cfg.cos_strict;
                2: c = cfg.cos_mid;
                3: c = cfg.cos_loose;
                4: c = cfg.cos_wide;
                default: c = -32768;
            endcase
            noang = c < longint'(COS_NO_ANGLE);
            mask = '0;
            for (int i = 0; i < n; i++)
            begin
                sx = tab_x[i];
                sy = tab_y[i];
                sz = tab_z[i];
                s2 = 128'(sx * sx + sy * sy + sz * sz);
                if (!tab_grp[i] || s2 == 0)
                    continue;
                if (!noang && !cone_pass(sx * ox + sy * oy + sz * oz, s2, o2, c))
                    continue;
                // Drop opposite-layer speakers on the two narrow tries
                if (t <= 2)
                begin
                    if (up && sz <= longint'(cfg.opposite_layer_z))
                        continue;
                    if (down && sz >= longint'(cfg.opposite_layer_z))
                        continue;
                end
                mask[i] = 1'b1;
            end
            cnt = $countones(mask);
            if (cnt >= MIN_SEL || noang)
                break;
        end
        if (t > 5)
            t = 5;
        r = '{mask, 6'(cnt), 3'(t)};
    endtask

    // Send one transaction, optionally after an idle burst
    task automatic send_item(input sel_item_t it, input bit typed, input sel_result_t typed_res);
        int          gap;
        bit          has;
        sel_result_t r;
        gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 10) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.operation        = it.op;
        in_ch.speaker_index    = it.idx;
        in_ch.speaker_x        = it.sx;
        in_ch.speaker_y        = it.sy;
        in_ch.speaker_z        = it.sz;
        in_ch.speaker_in_group = it.grp;
        in_ch.object_x         = it.ox;
        in_ch.object_y         = it.oy;
        in_ch.object_z         = it.oz;
        in_ch.object_flat      = it.flat;
        in_ch.valid            = 1'b1;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_selection(it, has, r);
        if (has)
            expected_selections.push_back(typed ? typed_res : r);
    endtask

    // Two-phase register write; update the predictor copy
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            CFG_SPEAKER_COUNT: cfg.speaker_count    = val[5:0];
            CFG_COS_STRICT:    cfg.cos_strict       = val[15:0];
            CFG_COS_MID:       cfg.cos_mid          = val[15:0];
            CFG_COS_LOOSE:     cfg.cos_loose        = val[15:0];
            CFG_COS_WIDE:      cfg.cos_wide         = val[15:0];
            CFG_STEEP_UZ:      cfg.steep_source_uz  = val[14:0];
            CFG_LAYER_Z:       cfg.opposite_layer_z = val[15:0];
            default:           cfg.horizontal_z_eps = val[14:0];
        endcase
    endtask

    // Wait until every result is in and loads have drained
    task automatic wait_idle();
        while (expected_selections.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_cos();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 65535));
            1: return -16'sd16384;
            2: return 16'sd16384;
            default: return 16'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    task automatic apply_phase_config(input int p);
        logic [31:0] v [8];
        case (p)
            0: v = '{32, 13377, 11585, 8192, 0, 11585, 0, 102};
            // Clamped count, narrowest cones, every source with nonzero z steep
            1: v = '{63, 16384, 16384, 16384, 16384, 0, 16'h8000, 0};
            // Angle test disabled on every try
            2: v = '{32, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16384, 16'h7fff, 32767};
            3: v = '{3, 16'hc000, 16'hc000, 16'hc000, 16'hc000, 16383, 16'hff00, 2000};
            4: v = '{0, 13377, 11585, 8192, 0, 11585, 0, 102};
            default:
            begin
                v[0] = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 63) : 32;
                v[1] = rand_cos();
                v[2] = rand_cos();
                v[3] = rand_cos();
                v[4] = rand_cos();
                v[5] = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 32767)
                                                   : $urandom_range(6000, 16384);
                v[6] = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 65535)
                                                   : 16'($urandom_range(0, 4000) - 2000);
                v[7] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                                   : $urandom_range(0, 1500);
            end
        endcase
        for (int i = 0; i < 8; i++)
            write_reg(3'(i), v[i]);
    endtask

    function automatic logic [15:0] rand_coord(input int mode);
        case (mode)
            0: return 16'($urandom_range(0, 4096) - 2048);
            1: return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(0, 16000) - 8000);
        endcase
    endfunction

    function automatic sel_item_t rand_load();
        sel_item_t it;
        int        mode;
        it = '0;
        it.op  = OP_LOAD;
        it.idx = 5'($urandom_range(0, 31));
        it.grp = $urandom_range(0, 5) != 0;
        mode = $urandom_range(0, 9);
        if (mode != 0)
        begin
            it.sx = rand_coord(mode % 3);
            it.sy = rand_coord(mode % 3);
            // Keep some speakers on the horizontal layer
            it.sz = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 300) - 150)
                                                : rand_coord(mode % 3);
        end
        it.ox = 16'($urandom_range(0, 65535));
        it.oy = 16'($urandom_range(0, 65535));
        it.oz = 16'($urandom_range(0, 65535));
        it.flat = $urandom_range(0, 1);
        return it;
    endfunction

    function automatic sel_item_t rand_query();
        sel_item_t it;
        int        mode;
        it = rand_load();
        it.op   = OP_QUERY;
        it.flat = $urandom_range(0, 4) == 0;
        mode = $urandom_range(0, 19);
        if (mode < 2)
        begin
            it.ox = '0;
            it.oy = '0;
            it.oz = '0;
        end
        else if (mode < 5)
        begin
            it.ox = 16'($urandom_range(0, 65535));
            it.oy = 16'($urandom_range(0, 65535));
            it.oz = 16'($urandom_range(0, 65535));
        end
        else if (mode < 9)
        begin
            // Steep source, up or down
            it.ox = 16'($urandom_range(0, 8000) - 4000);
            it.oy = 16'($urandom_range(0, 8000) - 4000);
            it.oz = $urandom_range(0, 1) ? 16'($urandom_range(10000, 16384))
                                         : -16'($urandom_range(10000, 16384));
        end
        else
        begin
            it.ox = 16'($urandom_range(0, 32768) - 16384);
            it.oy = 16'($urandom_range(0, 32768) - 16384);
            it.oz = 16'($urandom_range(0, 32768) - 16384);
        end
        return it;
    endfunction

    function automatic stim_row_t load_row(input int idx, input int x, input int y,
                                           input int z, input bit g);
        stim_row_t row;
        row.item = '0;
        row.item.op  = OP_LOAD;
        row.item.idx = 5'(idx);
        row.item.sx  = 16'(x);
        row.item.sy  = 16'(y);
        row.item.sz  = 16'(z);
        row.item.grp = g;
        row.typed = 1'b0;
        row.res = '0;
        return row;
    endfunction

    function automatic stim_row_t query_row(input int x, input int y, input int z,
                                            input bit f, input bit typed,
                                            input logic [2:0] tier);
        stim_row_t row;
        row.item = '0;
        row.item.op   = OP_QUERY;
        row.item.ox   = 16'(x);
        row.item.oy   = 16'(y);
        row.item.oz   = 16'(z);
        row.item.flat = f;
        row.typed = typed;
        row.res = '{32'd0, 6'd0, tier};
        return row;
    endfunction

    // Drive the result side ready with random stall bursts
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 9);
                out_ch.ready = 1'b0;
            end
            else
                out_ch.ready = 1'b1;
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        sel_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_selections.size() == 0)
                report_mismatch("unexpected result, mask", out_ch.speaker_mask, 0);
            else
            begin
                want = expected_selections.pop_front();
                if (out_ch.speaker_mask !== want.mask)
                    report_mismatch("speaker_mask", out_ch.speaker_mask, want.mask);
                if (out_ch.selected_count !== want.cnt)
                    report_mismatch("selected_count", out_ch.selected_count, want.cnt);
                if (out_ch.chosen_tier !== want.tier)
                    report_mismatch("chosen_tier", out_ch.chosen_tier, want.tier);
            end
        end
    end

    initial
    begin
        stim_row_t   rows[$];
        sel_result_t none;
        in_ch.valid = 1'b0;
        in_ch.operation = OP_LOAD;
        in_ch.speaker_index = '0;
        in_ch.speaker_x = '0;
        in_ch.speaker_y = '0;
        in_ch.speaker_z = '0;
        in_ch.speaker_in_group = 1'b0;
        in_ch.object_x = '0;
        in_ch.object_y = '0;
        in_ch.object_z = '0;
        in_ch.object_flat = 1'b0;
        none = '0;
        cfg = '{6'd0, 16'sd13377, 16'sd11585, 16'sd8192, 16'sd0, 15'd11585, 16'sd0, 15'd102};
        for (int i = 0; i < NUM_SPK; i++)
        begin
            tab_x[i] = '0;
            tab_y[i] = '0;
            tab_z[i] = '0;
            tab_grp[i] = 1'b0;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset count is zero, so queries select nothing
        rows.push_back(load_row(0, 32767, -32768, 0, 1));
        rows.push_back(load_row(31, -32768, 32767, 32767, 1));
        rows.push_back(load_row(1, 0, 0, 0, 1));
        rows.push_back(load_row(2, 1024, 0, -32768, 0));
        rows.push_back(query_row(0, 0, 0, 1'b1, 1'b1, TIER_FLAT));
        rows.push_back(query_row(0, 0, 0, 1'b0, 1'b1, TIER_GROUP));
        rows.push_back(query_row(16384, 0, 0, 1'b0, 1'b1, TIER_GROUP));
        rows.push_back(query_row(-16384, -16384, -16384, 1'b0, 1'b1, TIER_GROUP));
        rows.push_back(query_row(0, 0, 16384, 1'b0, 1'b1, TIER_GROUP));
        rows.push_back(query_row(-32768, 32767, -32768, 1'b0, 1'b1, TIER_GROUP));
        rows.push_back(query_row(32767, -32768, 32767, 1'b1, 1'b1, TIER_FLAT));
        foreach (rows[i])
            send_item(rows[i].item, rows[i].typed, rows[i].res);
        rows.delete();

        // Fill the whole table, then exercise the special cases at full count
        for (int i = 0; i < NUM_SPK; i++)
        begin
            sel_item_t it;
            it = rand_load();
            it.idx = 5'(i);
            send_item(it, 1'b0, none);
        end
        rows.push_back(load_row(3, 0, 0, 0, 1));
        rows.push_back(load_row(4, 2048, 0, 50, 1));
        rows.push_back(load_row(5, -2048, 0, -50, 1));
        rows.push_back(load_row(6, 0, 2048, 3000, 1));
        rows.push_back(load_row(7, 0, -2048, -3000, 1));
        foreach (rows[i])
            send_item(rows[i].item, 1'b0, none);
        rows.delete();
        @(negedge clk);
        in_ch.valid = 1'b0;
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            apply_phase_config(p);
            if (p == 0)
            begin
                rows.push_back(query_row(0, 0, 0, 1'b0, 1'b0, TIER_GROUP));
                rows.push_back(query_row(0, 0, 16384, 1'b0, 1'b0, TIER_GROUP));
                rows.push_back(query_row(0, 0, -16384, 1'b0, 1'b0, TIER_GROUP));
                rows.push_back(query_row(16384, 0, 0, 1'b0, 1'b0, TIER_GROUP));
                rows.push_back(query_row(0, 0, 0, 1'b1, 1'b0, TIER_FLAT));
                foreach (rows[i])
                    send_item(rows[i].item, 1'b0, none);
                rows.delete();
            end
            // Last part of the run goes without idling
            if (p == NUM_PHASES - 1)
                idle_on = 1'b0;
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_item(($urandom_range(0, 9) < 3) ? rand_load() : rand_query(), 1'b0, none);
            @(negedge clk);
            in_ch.valid = 1'b0;
        end

        wait_idle();
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
